[rtl/imm_pkg.sv]
`default_nettype none
package imm_pkg;
	localparam int WORD_W = 64;
	localparam int IDX_W = 2;
	localparam int MOD_REGS = 4;
	localparam logic [WORD_W-1:0] MOD_RESET0 = 64'h0000_0000_0000_C53B;
	localparam logic [1:0] ADDR_MOD0 = 2'd0;
	localparam logic [1:0] ADDR_MOD1 = 2'd1;
	localparam logic [1:0] ADDR_MOD2 = 2'd2;
	localparam logic [1:0] ADDR_MOD3 = 2'd3;

	typedef struct packed {
		logic [WORD_W-1:0] a_word;
		logic [WORD_W-1:0] b_word;
		logic [IDX_W-1:0]  word_index;
		logic              last_word;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_word;
		logic [IDX_W-1:0]  result_index;
		logic              result_last;
		logic              operand_error;
	} out_item_t;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_LOAD  = 8'b0000_0010,
		ST_CHECK = 8'b0000_0100,
		ST_BIT   = 8'b0000_1000,
		ST_DBL   = 8'b0001_0000,
		ST_ADD   = 8'b0010_0000,
		ST_OUT   = 8'b0100_0000,
		ST_WAIT  = 8'b1000_0000
	} state_t;
endpackage
`default_nettype wire

[rtl/imm_ram.sv]
`default_nettype none
module imm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/interleaved_modular_multiplier.sv]
`default_nettype none
// Modular multiplier: result = (a * b) mod m for operands of 64*OPERAND_WORDS bits.
// Feed OPERAND_WORDS items carrying one word each of a and b (any order, indexed by
// word_index); the item flagged last_word starts the computation. The operands sit in
// two word-wide RAMs; the full-width accumulator is held in a register and updated by
// one shared full-width add/compare unit. Each bit of a takes a double-and-reduce step,
// then an add-b-and-reduce step that is kept only if the bit is set; each word of a is
// fetched in a state of its own, and the load, wait and check states come before the
// scan. Input is stalled for the whole computation and drain; result words leave least
// significant first. If b >= m, m == 0 or the top bit of m is set, all result words are
// zero with operand_error set. The modulus is written through the APB port at byte
// addresses 8*i and reads back.
module interleaved_modular_multiplier
	import imm_pkg::*;
#(
	parameter int OPERAND_WORDS = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_item,
	input  wire logic      psel,
	input  wire logic      penable,
	input  wire logic      pwrite,
	input  wire logic [4:0] paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]    prdata,
	output logic           pready
);
	localparam int AW = (OPERAND_WORDS > 1) ? $clog2(OPERAND_WORDS) : 1;
	localparam int NB = WORD_W * OPERAND_WORDS;
	localparam int BW = $clog2(WORD_W);

	logic [WORD_W-1:0] mod_q [MOD_REGS];
	logic [NB-1:0] m_full, b_q, acc_q;
	state_t st_q;
	logic [AW-1:0] wcnt_q;
	logic [BW-1:0] bcnt_q;
	logic [WORD_W-1:0] a_word_q;
	logic err_q;
	logic [AW-1:0] raddr;
	logic [WORD_W-1:0] a_rd, b_rd;
	logic wr_en, in_acc;
	logic [1:0] reg_sel;

	assign pready = 1'b1;
	assign reg_sel = paddr[4:3];
	assign wr_en = psel && penable && pwrite;

	// hold the modulus registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q[0] <= MOD_RESET0;
			mod_q[1] <= '0;
			mod_q[2] <= '0;
			mod_q[3] <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				ADDR_MOD0: mod_q[0] <= pwdata;
				ADDR_MOD1: mod_q[1] <= pwdata;
				ADDR_MOD2: mod_q[2] <= pwdata;
				ADDR_MOD3: mod_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			ADDR_MOD0: prdata = mod_q[0];
			ADDR_MOD1: prdata = mod_q[1];
			ADDR_MOD2: prdata = mod_q[2];
			ADDR_MOD3: prdata = mod_q[3];
			default:   prdata = '0;
		endcase
	end

	// widen the modulus; words beyond the registers read as zero
	always_comb begin
		m_full = '0;
		for (int i = 0; i < OPERAND_WORDS; i++)
			if (i < MOD_REGS) m_full[i*WORD_W +: WORD_W] = mod_q[i];
	end

	assign in_stall = (st_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;

	logic st_we;
	logic [AW-1:0] st_waddr;
	assign st_we = in_acc && ({1'b0, in_item.word_index} < (IDX_W+1)'(OPERAND_WORDS));
	assign st_waddr = AW'(in_item.word_index);

	imm_ram #(.WIDTH(WORD_W), .DEPTH(OPERAND_WORDS)) u_a_ram (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(in_item.a_word),
		.raddr(raddr), .rdata(a_rd));
	imm_ram #(.WIDTH(WORD_W), .DEPTH(OPERAND_WORDS)) u_b_ram (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(in_item.b_word),
		.raddr(raddr), .rdata(b_rd));

	assign raddr = wcnt_q;

	// shared step unit: optional double or add, then conditional subtract
	logic [NB:0] pre, diff;
	logic dbl_sel;
	assign dbl_sel = (st_q == ST_DBL);
	always_comb begin
		pre = dbl_sel ? {acc_q, 1'b0} : ({1'b0, acc_q} + {1'b0, b_q});
		diff = pre - {1'b0, m_full};
	end
	logic [NB-1:0] step_res;
	assign step_res = diff[NB] ? pre[NB-1:0] : diff[NB-1:0];

	logic a_bit;
	assign a_bit = a_word_q[bcnt_q];

	// sequence load, bit scan and result drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			wcnt_q <= '0;
			bcnt_q <= '0;
			err_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: if (in_acc && in_item.last_word) begin
					st_q <= ST_LOAD;
					wcnt_q <= '0;
				end
				ST_LOAD: begin
					// rdata holds word wcnt_q-1, registered from the previous cycle's address
					if (wcnt_q == AW'(OPERAND_WORDS - 1)) st_q <= ST_WAIT;
					else wcnt_q <= wcnt_q + 1'b1;
				end
				ST_WAIT: st_q <= ST_CHECK;
				ST_CHECK: begin
					err_q <= (m_full == '0) || m_full[NB-1] || (b_q >= m_full);
					if ((m_full == '0) || m_full[NB-1] || (b_q >= m_full)) begin
						st_q <= ST_OUT;
						wcnt_q <= '0;
						out_valid <= 1'b1;
					end else begin
						st_q <= ST_BIT;
						wcnt_q <= AW'(OPERAND_WORDS - 1);
					end
				end
				ST_BIT: begin
					bcnt_q <= BW'(WORD_W - 1);
					st_q <= ST_DBL;
				end
				ST_DBL: st_q <= ST_ADD;
				ST_ADD: begin
					if (bcnt_q != '0) begin
						bcnt_q <= bcnt_q - 1'b1;
						st_q <= ST_DBL;
					end else if (wcnt_q != '0) begin
						wcnt_q <= wcnt_q - 1'b1;
						st_q <= ST_BIT;
					end else begin
						st_q <= ST_OUT;
						out_valid <= 1'b1;
					end
				end
				ST_OUT: if (!out_stall) begin
					if (wcnt_q == AW'(OPERAND_WORDS - 1)) begin
						out_valid <= 1'b0;
						st_q <= ST_IDLE;
					end else wcnt_q <= wcnt_q + 1'b1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers: b gather, a word, accumulator
	logic [AW-1:0] prev_q;
	always_ff @(posedge clk) begin
		prev_q <= wcnt_q;
		if (st_q == ST_IDLE) acc_q <= '0;
		if (st_q == ST_LOAD || st_q == ST_WAIT)
			b_q[prev_q*WORD_W +: WORD_W] <= b_rd;
		if (st_q == ST_DBL) begin
			acc_q <= step_res;
			if (bcnt_q == BW'(WORD_W - 1)) a_word_q <= a_rd;
		end
		if (st_q == ST_ADD && a_bit) acc_q <= step_res;
	end

	// the a word is read from the address held in ST_BIT and is ready in the next state,
	// where the DBL step above latches it; the bit test in ADD uses the latched word
	assign out_item.result_word = err_q ? '0 : acc_q[wcnt_q*WORD_W +: WORD_W];
	assign out_item.result_index = IDX_W'(wcnt_q);
	assign out_item.result_last = (wcnt_q == AW'(OPERAND_WORDS - 1));
	assign out_item.operand_error = err_q;
endmodule
`default_nettype wire
